// File: rtl/spgt_pkg.sv
`default_nettype none

package spgt_pkg;

  // Widths fixed by the event and result formats.
  localparam int unsigned CFG_W    = 64;
  localparam int unsigned OUT_ID_W = 63;
  localparam int unsigned PHASE_W  = 3;

  // Phase codes shared by the gesture and momentum fields.
  localparam logic [PHASE_W-1:0] PH_NONE     = 3'd0;
  localparam logic [PHASE_W-1:0] PH_BEGAN    = 3'd1;
  localparam logic [PHASE_W-1:0] PH_STAT     = 3'd2;
  localparam logic [PHASE_W-1:0] PH_CHANGED  = 3'd3;
  localparam logic [PHASE_W-1:0] PH_ENDED    = 3'd4;
  localparam logic [PHASE_W-1:0] PH_CANCELED = 3'd5;
  localparam logic [PHASE_W-1:0] PH_MAYBEGIN = 3'd6;
  localparam logic [PHASE_W-1:0] PH_UNKNOWN  = 3'd7;

  // Command codes.
  localparam logic CMD_RESOLVE = 1'b0;
  localparam logic CMD_CLEANUP = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE     = 2'd0,
    ST_GESTURE  = 2'd1,
    ST_PENDING  = 2'd2,
    ST_MOMENTUM = 2'd3
  } tracker_state_t;

  typedef enum logic [1:0] {
    K_NONE     = 2'd0,
    K_RESOLVED = 2'd1,
    K_FAIL     = 2'd2
  } result_kind_t;

  typedef enum logic [2:0] {
    F_NONE    = 3'd0,
    F_GBITS   = 3'd1,
    F_MBITS   = 3'd2,
    F_TRANS   = 3'd3,
    F_EXHAUST = 3'd4
  } failure_t;

  typedef struct packed {
    logic               cmd;
    logic               gesture_valid;
    logic [PHASE_W-1:0] gesture_phase;
    logic               momentum_valid;
    logic [PHASE_W-1:0] momentum_phase;
    logic               cleanup_ok;
  } spgt_in_t;

  typedef struct packed {
    logic [1:0]          result_kind;
    logic [OUT_ID_W-1:0] gesture_id;
    logic [PHASE_W-1:0]  gesture_phase_out;
    logic [PHASE_W-1:0]  momentum_phase_out;
    logic [2:0]          failure_code;
    logic [1:0]          tracker_state_out;
  } spgt_out_t;

endpackage

`default_nettype wire

// File: rtl/spgt_if.sv
`default_nettype none

// Event channel into the tracker.
interface spgt_in_if;
  logic               valid;
  logic               ready;
  spgt_pkg::spgt_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// Result channel out of the tracker.
interface spgt_out_if;
  logic                valid;
  logic                ready;
  spgt_pkg::spgt_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// Write channel for the next gesture id register.
interface spgt_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [spgt_pkg::CFG_W-1:0]   data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/scroll_phase_gesture_tracker_unit.sv
`default_nettype none

// Scroll phase gesture tracker. Each resolve beat on in_bus (cmd 0) yields exactly one
// result beat on out_bus; a cleanup beat (cmd 1) yields none and, with cleanup_ok set,
// returns the tracker to idle with the next gesture id at 1 and any sticky failure
// cleared. The tracker state and id counters update in the cycle a beat is accepted,
// and the result lands in a single output register, so one beat is taken every clock
// while the output register is empty or being drained, and the sustained rate is one
// beat per cycle. A write on cfg_bus loads the next gesture id
// (low ID_BITS bits, two's complement); it is always ready and resets to 1.
module scroll_phase_gesture_tracker_unit #(
  parameter int unsigned ID_BITS = 64
) (
  input  wire              clk,
  input  wire              rst_n,
  spgt_in_if.sink          in_bus,
  spgt_out_if.source       out_bus,
  spgt_cfg_if.sink         cfg_bus
);

  localparam int unsigned CUR_W     = ID_BITS - 1;
  localparam int unsigned PHASE_W_L = spgt_pkg::PHASE_W;

  // Tracker state.
  spgt_pkg::tracker_state_t state_r, state_nxt;
  logic [CUR_W-1:0]         cur_id_r, cur_id_nxt;
  logic [ID_BITS-1:0]       next_id_r, next_id_nxt;
  spgt_pkg::failure_t       sticky_r, sticky_nxt;

  // Output register.
  logic                     out_valid_r, out_valid_nxt;
  spgt_pkg::spgt_out_t      out_data_r, out_data_nxt;

  logic                     in_fire;
  logic                     cfg_fire;
  logic                     g_bad, m_bad;
  logic                     exhausted;
  logic [PHASE_W_L-1:0]     g, m;
  spgt_pkg::result_kind_t   kind;
  spgt_pkg::failure_t       fcode;
  logic [PHASE_W_L-1:0]     g_o, m_o;
  logic [CUR_W-1:0]         res_id;
  spgt_pkg::tracker_state_t st_step;
  logic [CUR_W-1:0]         cur_step;
  logic [ID_BITS-1:0]       nid_step;

  assign in_bus.ready  = !out_valid_r || out_bus.ready;
  assign in_fire       = in_bus.valid && in_bus.ready;
  assign cfg_bus.ready = 1'b1;
  assign cfg_fire      = cfg_bus.valid;

  assign g     = in_bus.data.gesture_phase;
  assign m     = in_bus.data.momentum_phase;
  assign g_bad = !in_bus.data.gesture_valid || (g == spgt_pkg::PH_UNKNOWN);
  assign m_bad = !in_bus.data.momentum_valid || (m == spgt_pkg::PH_UNKNOWN);

  // Id counter is spent at zero, at negative values and at its maximum.
  assign exhausted = (next_id_r == '0) || next_id_r[ID_BITS-1] ||
                     (next_id_r[CUR_W-1:0] == {CUR_W{1'b1}});

  // Resolve one event against the current state.
  always_comb begin
    st_step  = state_r;
    cur_step = cur_id_r;
    nid_step = next_id_r;
    kind     = spgt_pkg::K_FAIL;
    fcode    = spgt_pkg::F_TRANS;
    g_o      = g;
    m_o      = m;
    res_id   = cur_id_r;
    if (sticky_r != spgt_pkg::F_NONE) begin
      fcode = sticky_r;
      g_o   = spgt_pkg::PH_UNKNOWN;
      m_o   = spgt_pkg::PH_UNKNOWN;
    end else if (g_bad) begin
      fcode = spgt_pkg::F_GBITS;
      g_o   = spgt_pkg::PH_UNKNOWN;
      m_o   = spgt_pkg::PH_UNKNOWN;
    end else if (m_bad) begin
      fcode = spgt_pkg::F_MBITS;
      m_o   = spgt_pkg::PH_UNKNOWN;
    end else if (g == spgt_pkg::PH_NONE && m == spgt_pkg::PH_NONE) begin
      kind  = spgt_pkg::K_NONE;
      fcode = spgt_pkg::F_NONE;
    end else begin
      unique case (state_r)
        spgt_pkg::ST_IDLE: begin
          if ((g == spgt_pkg::PH_MAYBEGIN && m == spgt_pkg::PH_NONE) ||
              (g == spgt_pkg::PH_NONE && m == spgt_pkg::PH_MAYBEGIN)) begin
            kind  = spgt_pkg::K_NONE;
            fcode = spgt_pkg::F_NONE;
          end else if (g == spgt_pkg::PH_BEGAN && m == spgt_pkg::PH_NONE) begin
            if (exhausted) begin
              fcode = spgt_pkg::F_EXHAUST;
            end else begin
              kind     = spgt_pkg::K_RESOLVED;
              fcode    = spgt_pkg::F_NONE;
              cur_step = next_id_r[CUR_W-1:0];
              res_id   = next_id_r[CUR_W-1:0];
              nid_step = next_id_r + ID_BITS'(1);
              st_step  = spgt_pkg::ST_GESTURE;
            end
          end
        end
        spgt_pkg::ST_GESTURE: begin
          if (m == spgt_pkg::PH_NONE &&
              (g == spgt_pkg::PH_CHANGED || g == spgt_pkg::PH_STAT)) begin
            kind  = spgt_pkg::K_RESOLVED;
            fcode = spgt_pkg::F_NONE;
          end else if (g == spgt_pkg::PH_ENDED && m == spgt_pkg::PH_NONE) begin
            kind    = spgt_pkg::K_RESOLVED;
            fcode   = spgt_pkg::F_NONE;
            st_step = spgt_pkg::ST_PENDING;
          end else if (g == spgt_pkg::PH_CANCELED && m == spgt_pkg::PH_NONE) begin
            kind     = spgt_pkg::K_RESOLVED;
            fcode    = spgt_pkg::F_NONE;
            st_step  = spgt_pkg::ST_IDLE;
            cur_step = '0;
          end else if (g == spgt_pkg::PH_ENDED && m == spgt_pkg::PH_BEGAN) begin
            kind    = spgt_pkg::K_RESOLVED;
            fcode   = spgt_pkg::F_NONE;
            st_step = spgt_pkg::ST_MOMENTUM;
          end
        end
        spgt_pkg::ST_PENDING: begin
          if (g == spgt_pkg::PH_NONE && m == spgt_pkg::PH_BEGAN) begin
            kind    = spgt_pkg::K_RESOLVED;
            fcode   = spgt_pkg::F_NONE;
            st_step = spgt_pkg::ST_MOMENTUM;
          end else if (g == spgt_pkg::PH_BEGAN && m == spgt_pkg::PH_NONE) begin
            if (exhausted) begin
              fcode = spgt_pkg::F_EXHAUST;
            end else begin
              kind     = spgt_pkg::K_RESOLVED;
              fcode    = spgt_pkg::F_NONE;
              cur_step = next_id_r[CUR_W-1:0];
              res_id   = next_id_r[CUR_W-1:0];
              nid_step = next_id_r + ID_BITS'(1);
              st_step  = spgt_pkg::ST_GESTURE;
            end
          end
        end
        spgt_pkg::ST_MOMENTUM: begin
          if (g == spgt_pkg::PH_NONE &&
              (m == spgt_pkg::PH_CHANGED || m == spgt_pkg::PH_STAT)) begin
            kind  = spgt_pkg::K_RESOLVED;
            fcode = spgt_pkg::F_NONE;
          end else if (g == spgt_pkg::PH_NONE &&
                       (m == spgt_pkg::PH_ENDED || m == spgt_pkg::PH_CANCELED)) begin
            kind     = spgt_pkg::K_RESOLVED;
            fcode    = spgt_pkg::F_NONE;
            st_step  = spgt_pkg::ST_IDLE;
            cur_step = '0;
          end
        end
        default: begin
          kind = spgt_pkg::K_FAIL;
        end
      endcase
    end
  end

  // Commit the step, cleanup or configuration write.
  always_comb begin
    state_nxt   = state_r;
    cur_id_nxt  = cur_id_r;
    next_id_nxt = next_id_r;
    sticky_nxt  = sticky_r;
    if (in_fire) begin
      if (in_bus.data.cmd == spgt_pkg::CMD_RESOLVE) begin
        state_nxt   = st_step;
        cur_id_nxt  = cur_step;
        next_id_nxt = nid_step;
        if (kind == spgt_pkg::K_FAIL) begin
          sticky_nxt = fcode;
        end
      end else if (in_bus.data.cleanup_ok) begin
        state_nxt   = spgt_pkg::ST_IDLE;
        cur_id_nxt  = '0;
        next_id_nxt = ID_BITS'(1);
        sticky_nxt  = spgt_pkg::F_NONE;
      end
    end
    if (cfg_fire) begin
      next_id_nxt = cfg_bus.data[ID_BITS-1:0];
    end
  end

  // Output register: loaded on a resolve beat, emptied when taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (in_fire) begin
      out_valid_nxt                   = (in_bus.data.cmd == spgt_pkg::CMD_RESOLVE);
      out_data_nxt.result_kind        = kind;
      out_data_nxt.gesture_id         = (kind == spgt_pkg::K_RESOLVED) ?
                                        spgt_pkg::OUT_ID_W'(res_id) : '0;
      out_data_nxt.gesture_phase_out  = g_o;
      out_data_nxt.momentum_phase_out = m_o;
      out_data_nxt.failure_code       = fcode;
      out_data_nxt.tracker_state_out  = st_step;
    end else if (out_bus.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= spgt_pkg::ST_IDLE;
      cur_id_r    <= '0;
      next_id_r   <= ID_BITS'(1);
      sticky_r    <= spgt_pkg::F_NONE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_id_r    <= cur_id_nxt;
      next_id_r   <= next_id_nxt;
      sticky_r    <= sticky_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_bus.valid = out_valid_r;
  assign out_bus.data  = out_data_r;

  // A resolved beat always carries a live, nonzero id.
  a_resolved_id: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.result_kind == spgt_pkg::K_RESOLVED |->
      out_data_r.gesture_id != '0)
    else $error("resolved result with zero gesture id");

  // A failure beat has a code and no id; other beats have no code.
  a_fail_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |->
      ((out_data_r.result_kind == spgt_pkg::K_FAIL) ==
       (out_data_r.failure_code != spgt_pkg::F_NONE)) &&
      (out_data_r.result_kind != spgt_pkg::K_FAIL || out_data_r.gesture_id == '0))
    else $error("failure code and result kind disagree");

  // A successful cleanup leaves the tracker idle with no sticky failure.
  a_cleanup: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_bus.data.cmd == spgt_pkg::CMD_CLEANUP && in_bus.data.cleanup_ok |=>
      state_r == spgt_pkg::ST_IDLE && sticky_r == spgt_pkg::F_NONE && cur_id_r == '0)
    else $error("cleanup did not reset the tracker");

  // Only idle or pending gestures may take a fresh id.
  a_id_advance: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !cfg_fire && in_bus.data.cmd == spgt_pkg::CMD_RESOLVE &&
      next_id_nxt != next_id_r |->
      (state_r == spgt_pkg::ST_IDLE || state_r == spgt_pkg::ST_PENDING) &&
      state_nxt == spgt_pkg::ST_GESTURE)
    else $error("gesture id advanced outside a gesture start");

endmodule

`default_nettype wire
